FILE: hw/rtl/eca_reversibility_check_macros.svh
// ----------------------------------------------------------------------------
// eca_reversibility_check_macros.svh
// Assertion macros shared by the checker of the ECA reversibility block.
// Both sample on clk and are disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ECA_REVERSIBILITY_CHECK_MACROS_SVH
`define ECA_REVERSIBILITY_CHECK_MACROS_SVH

// Consequent checked in the cycle after the antecedent.
`define ECA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent checked in the same cycle as the antecedent.
`define ECA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/eca_pkg.sv
// ----------------------------------------------------------------------------
// eca_pkg
// Sizes, types and helpers for the ECA reversibility block.
// ----------------------------------------------------------------------------
package eca_pkg;

    localparam int MAX_CELLS = 16;
    localparam int RULE_W    = 8;
    localparam int CELL_IN_W = 5;
    localparam int CNT_W     = $clog2(MAX_CELLS + 1);
    localparam int IDX_W     = $clog2(MAX_CELLS);

    // Seen bitmap stored as rows of ROW_W bits.
    localparam int ROW_W     = 8;
    localparam int ROW_SHIFT = $clog2(ROW_W);
    localparam int ROW_AW    = (MAX_CELLS > ROW_SHIFT + 1) ? (MAX_CELLS - ROW_SHIFT) : 1;
    localparam int ROW_DEPTH = 1 << ROW_AW;

    typedef logic [MAX_CELLS-1:0] cfg_t;
    typedef logic [ROW_AW-1:0]    row_addr_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [ROW_SHIFT-1:0] row_bit_t;

    typedef struct packed {
        logic [RULE_W-1:0] rule;
        logic [CNT_W-1:0]  n;
        logic              wrap;
    } query_t;

    typedef struct packed {
        logic      we;
        logic      re;
        row_addr_t addr;
        row_t      wdata;
    } mem_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_STEP,
        ST_READ,
        ST_CHECK,
        ST_FIN
    } state_t;

    function automatic row_addr_t row_of(input cfg_t c);
        return row_addr_t'(c >> ROW_SHIFT);
    endfunction

    function automatic row_bit_t bit_of(input cfg_t c);
        return c[ROW_SHIFT-1:0];
    endfunction

endpackage

FILE: hw/rtl/eca_ram.sv
// ----------------------------------------------------------------------------
// eca_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module eca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/eca_step.sv
// ----------------------------------------------------------------------------
// eca_step
// One generation of the automaton on a configuration word, registered.
// ----------------------------------------------------------------------------
module eca_step import eca_pkg::*; (
    input  logic   clk,
    input  query_t query,
    input  cfg_t   cur,
    input  logic   load,
    output cfg_t   succ
);

    cfg_t                 succ_next;
    cfg_t                 succ_reg;
    logic [IDX_W-1:0]     top_idx;

    // Highest live cell; only used when at least one cell is live.
    assign top_idx = IDX_W'(query.n - CNT_W'(1));

    for (genvar b = 0; b < MAX_CELLS; b++)
    begin : g_cell
        logic lft;
        logic rgt;
        logic act;
        logic [2:0] pat;

        assign act = (query.n > CNT_W'(b));

        if (b + 1 < MAX_CELLS)
        begin : g_left_in
            assign lft = (query.n == CNT_W'(b + 1)) ? (query.wrap & cur[0]) : cur[b + 1];
        end
        else
        begin : g_left_edge
            assign lft = query.wrap & cur[0];
        end

        if (b == 0)
        begin : g_right_edge
            assign rgt = query.wrap & cur[top_idx];
        end
        else
        begin : g_right_in
            assign rgt = cur[b - 1];
        end

        assign pat          = {lft, cur[b], rgt};
        assign succ_next[b] = act & query.rule[pat];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            succ_reg <= succ_next;
        end
    end

    assign succ = succ_reg;

endmodule

FILE: hw/rtl/eca_ctrl.sv
// ----------------------------------------------------------------------------
// eca_ctrl
// Query sequencer: bitmap clear, per-configuration read-check-write, result.
// ----------------------------------------------------------------------------
module eca_ctrl import eca_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RULE_W-1:0]    rule_number,
    input  logic [CELL_IN_W-1:0] cell_count,
    input  logic                 periodic_mode,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 reversible,
    output query_t               query,
    output cfg_t                 cur,
    output logic                 succ_load,
    input  cfg_t                 succ,
    output mem_req_t             mem_req,
    input  row_t                 mem_rdata
);

    state_t     state_reg, state_next;
    query_t     query_reg;
    cfg_t       cur_reg;
    cfg_t       mask_reg;
    row_addr_t  clr_addr_reg;
    logic       answer_reg;
    logic       out_valid_reg;
    logic       reversible_reg;

    logic [CNT_W-1:0]   n_sat;
    logic [MAX_CELLS:0] pow;
    cfg_t               mask_next;
    logic               accept;
    logic               hit;
    logic               last_cfg;
    logic               clr_done;
    logic               slot_free;

    assign n_sat = (cell_count > CELL_IN_W'(MAX_CELLS)) ? CNT_W'(MAX_CELLS)
                                                         : CNT_W'(cell_count);
    assign pow       = (MAX_CELLS + 1)'(1) << n_sat;
    assign mask_next = pow[MAX_CELLS-1:0] - MAX_CELLS'(1);

    assign accept    = in_valid && in_ready;
    assign hit       = mem_rdata[bit_of(succ)];
    assign last_cfg  = (cur_reg == mask_reg);
    assign clr_done  = (clr_addr_reg == ROW_AW'(ROW_DEPTH - 1));
    assign slot_free = !out_valid_reg || out_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_CLEAR;
            ST_CLEAR: if (clr_done) state_next = ST_STEP;
            ST_STEP:  state_next = ST_READ;
            ST_READ:  state_next = ST_CHECK;
            ST_CHECK: state_next = (hit || last_cfg) ? ST_FIN : ST_STEP;
            ST_FIN:   if (slot_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready      = 1'b0;
        succ_load     = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.re    = 1'b0;
        mem_req.addr  = row_of(succ);
        mem_req.wdata = mem_rdata | (row_t'(1) << bit_of(succ));
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.addr  = clr_addr_reg;
                mem_req.wdata = '0;
            end
            ST_STEP:  succ_load = 1'b1;
            ST_READ:  mem_req.re = 1'b1;
            ST_CHECK: mem_req.we = !hit;
            ST_FIN:   in_ready = 1'b0;
            default:  in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_FIN && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            query_reg    <= '{rule: rule_number, n: n_sat, wrap: periodic_mode};
            mask_reg     <= mask_next;
            cur_reg      <= '0;
            clr_addr_reg <= '0;
        end
        if (state_reg == ST_CLEAR)
        begin
            clr_addr_reg <= clr_addr_reg + ROW_AW'(1);
        end
        if (state_reg == ST_CHECK)
        begin
            answer_reg <= !hit;
            cur_reg    <= cur_reg + MAX_CELLS'(1);
        end
        if (state_reg == ST_FIN && slot_free)
        begin
            reversible_reg <= answer_reg;
        end
    end

    assign query      = query_reg;
    assign cur        = cur_reg;
    assign out_valid  = out_valid_reg;
    assign reversible = reversible_reg;

endmodule

FILE: hw/rtl/eca_reversibility_check.sv
// ----------------------------------------------------------------------------
// eca_reversibility_check
// Injectivity test of an elementary cellular automaton over all 2^n configurations, ring or zero-boundary.
//
//   Channel  Handshake            Beat contents
//   in       in_valid / in_ready  rule_number, cell_count, periodic_mode
//   out      out_valid/ out_ready reversible
//
// A query steps the configurations in order until the first repeated
//   successor, or through all 2^n of them if the rule is reversible.
//   ROW_DEPTH, the number of bitmap rows, is 8192 at 16 cells.
// The clear pass writes one bitmap row per cycle; each configuration then
//   costs step, read, check/write through the single RAM port pair.
// Reset: asynchronous, clears only the sequencer and output valid; the
//   bitmap is cleared at the start of every query, never by reset.
// Stalls: a new query is taken only when idle; a finished answer waits in
//   the sequencer, which holds in its final state until the output
//   register is free.
// ----------------------------------------------------------------------------
module eca_reversibility_check import eca_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RULE_W-1:0]    rule_number,
    input  logic [CELL_IN_W-1:0] cell_count,
    input  logic                 periodic_mode,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 reversible
);

    query_t   query;
    cfg_t     cur;
    cfg_t     succ;
    logic     succ_load;
    mem_req_t mem_req;
    row_t     mem_rdata;

    // Sequencer: owns the query, the configuration counter and the bitmap
    // access order. Read (READ) and its write-back (CHECK) never overlap the
    // next read, so no forwarding path is needed.
    eca_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rule_number   (rule_number),
        .cell_count    (cell_count),
        .periodic_mode (periodic_mode),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .reversible    (reversible),
        .query         (query),
        .cur           (cur),
        .succ_load     (succ_load),
        .succ          (succ),
        .mem_req       (mem_req),
        .mem_rdata     (mem_rdata)
    );

    // Successor of the current configuration under the query's rule.
    eca_step u_step (
        .clk   (clk),
        .query (query),
        .cur   (cur),
        .load  (succ_load),
        .succ  (succ)
    );

    // Seen bitmap, ROW_W bits per row.
    eca_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROW_DEPTH)
    ) u_seen (
        .clk   (clk),
        .we    (mem_req.we),
        .waddr (mem_req.addr),
        .wdata (mem_req.wdata),
        .re    (mem_req.re),
        .raddr (mem_req.addr),
        .rdata (mem_rdata)
    );

endmodule

FILE: hw/rtl/eca_chk.sv
// ----------------------------------------------------------------------------
// eca_chk
// Port-level checks for the ECA reversibility block, bound to the top level.
// ----------------------------------------------------------------------------
`include "eca_reversibility_check_macros.svh"

module eca_chk import eca_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic [RULE_W-1:0]    rule_number,
    input logic [CELL_IN_W-1:0] cell_count,
    input logic                 periodic_mode,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 reversible
);

    `ECA_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(rule_number) && $stable(cell_count) && $stable(periodic_mode), "input beat dropped or changed while stalled")
    `ECA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(reversible), "output beat dropped or changed while stalled")
    `ECA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready ##1 !in_ready, "query accepted while previous one still running")
    `ECA_ASSERT_SAME(a_result_after_work, $rose(out_valid), $past(!in_ready), "result raised without a query in progress")

endmodule

bind eca_reversibility_check eca_chk u_chk (.*);
